// ----- design/bse_pkg.sv -----
// Shared types and constants for the bubble sort engine.
package bse_pkg;

	localparam int DEPTH  = 64;
	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic [CNT_W-1:0] count_t;

	// Controls broadcast from the sequencer to every cell
	typedef struct packed {
		logic unload;
	} ctl_t;

endpackage

// ----- design/bse_cell.sv -----
// One sorting cell: keeps the smaller word, passes the larger one on.
module bse_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  bse_pkg::ctl_t ctl,
	input  logic          tok_in_vld,
	input  bse_pkg::word_t tok_in_val,
	output logic          tok_out_vld,
	output bse_pkg::word_t tok_out_val,
	input  logic          nxt_vld,
	input  bse_pkg::word_t nxt_val,
	output logic          held_vld,
	output bse_pkg::word_t held_val
);

	logic          held_vld_q;
	bse_pkg::word_t held_val_q;
	logic          tok_vld_q;
	bse_pkg::word_t tok_val_q;
	logic          take_new;

	assign take_new = tok_in_val < held_val_q;

	// Hold the smaller word, advance the larger; shift towards the head on unload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q <= 1'b0;
			tok_vld_q  <= 1'b0;
		end else if (ctl.unload) begin
			held_vld_q <= nxt_vld;
			tok_vld_q  <= 1'b0;
		end else if (tok_in_vld) begin
			held_vld_q <= 1'b1;
			tok_vld_q  <= held_vld_q;
		end else begin
			tok_vld_q <= 1'b0;
		end
	end

	// Payload path, no reset
	always_ff @(posedge clk) begin
		if (ctl.unload) begin
			held_val_q <= nxt_val;
		end else if (tok_in_vld) begin
			if (!held_vld_q || take_new) begin
				held_val_q <= tok_in_val;
				tok_val_q  <= held_val_q;
			end else begin
				tok_val_q <= tok_in_val;
			end
		end
	end

	assign tok_out_vld = tok_vld_q;
	assign tok_out_val = tok_val_q;
	assign held_vld    = held_vld_q;
	assign held_val    = held_val_q;

endmodule

// ----- design/bse_ctrl.sv -----
// Sequencer: counts the set, waits for the chain to settle, drains it.
module bse_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          last,
	output logic          in_ready,
	output logic          store,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          final_res,
	output bse_pkg::ctl_t ctl
);

	typedef enum logic [2:0] {
		ST_LOAD   = 3'b001,
		ST_SETTLE = 3'b010,
		ST_UNLOAD = 3'b100
	} state_t;

	state_t          state_q;
	bse_pkg::count_t count_q;
	bse_pkg::count_t wait_q;
	logic            in_acc;
	logic            out_acc;
	logic            room;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign room    = count_q < bse_pkg::CNT_W'(bse_pkg::DEPTH);

	assign in_ready   = state_q == ST_LOAD;
	assign out_valid  = state_q == ST_UNLOAD;
	assign store      = in_acc && room;
	assign final_res  = count_q == bse_pkg::CNT_W'(1);
	assign ctl.unload = out_acc;

	// Advance through load, settle and unload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			wait_q  <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (room) begin
							count_q <= count_q + bse_pkg::CNT_W'(1);
						end
						if (last) begin
							state_q <= ST_SETTLE;
							wait_q  <= bse_pkg::CNT_W'(bse_pkg::DEPTH - 1);
						end
					end
				end
				ST_SETTLE: begin
					if (wait_q == '0) begin
						state_q <= ST_UNLOAD;
					end else begin
						wait_q <= wait_q - bse_pkg::CNT_W'(1);
					end
				end
				ST_UNLOAD: begin
					if (out_acc) begin
						count_q <= count_q - bse_pkg::CNT_W'(1);
						if (final_res) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

// ----- design/bubble_sort_engine.sv -----
// Top level of the bubble sort engine: sequencer and chain of sorting cells.
// Accepts a set of signed 32-bit words, one per cycle, the last marked by
// last; up to 64 are kept and further words are dropped, though a dropped
// word marked last still closes the set. Each word enters the head of a
// row of 64 cells and ripples down one cell per cycle, every cell keeping
// the smaller word and passing the larger on. After the last word the
// chain is left to settle, then the set is emitted smallest first, one
// word per cycle while out_ready is high, with final_res on the last one.
// No input is taken while the chain settles or drains.
module bubble_sort_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bse_pkg::word_t value,
	input  logic           last,
	output logic           out_valid,
	input  logic           out_ready,
	output bse_pkg::word_t sorted_value,
	output logic           final_res
);

	localparam int N = bse_pkg::DEPTH;

	bse_pkg::ctl_t  ctl;
	logic           store;
	logic           tok_vld [N+1];
	bse_pkg::word_t tok_val [N+1];
	logic           held_vld [N+1];
	bse_pkg::word_t held_val [N+1];

	bse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.in_ready  (in_ready),
		.store     (store),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.final_res (final_res),
		.ctl       (ctl)
	);

	// Feed the head of the chain; nothing beyond the tail
	assign tok_vld[0]  = store;
	assign tok_val[0]  = value;
	assign held_vld[N] = 1'b0;
	assign held_val[N] = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		bse_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.tok_in_vld  (tok_vld[i]),
			.tok_in_val  (tok_val[i]),
			.tok_out_vld (tok_vld[i+1]),
			.tok_out_val (tok_val[i+1]),
			.nxt_vld     (held_vld[i+1]),
			.nxt_val     (held_val[i+1]),
			.held_vld    (held_vld[i]),
			.held_val    (held_val[i])
		);
	end

	assign sorted_value = held_val[0];

endmodule

// ----- sim/bubble_sort_engine_tb.sv -----
// Self-checking testbench for the bubble sort engine, with a sorting predictor and random traffic.
`timescale 1ns / 100ps

module bubble_sort_engine_tb;

	// One word offered to the engine; typed rows carry their own expected result
	typedef struct packed {
		bse_pkg::word_t v;
		logic           l;
		logic           typed;
		bse_pkg::word_t exp_v;
	} word_req_t;

	// One word expected back from the engine
	typedef struct packed {
		bse_pkg::word_t v;
		logic           fin;
	} sorted_t;

	typedef enum logic [1:0] {RX_FREE, RX_PATTERN, RX_COIN} rx_mode_t;

	localparam bse_pkg::word_t W_MIN        = 32'sh8000_0000;
	localparam bse_pkg::word_t W_MAX        = 32'sh7fff_ffff;
	localparam bse_pkg::word_t W_ONES       = -32'sd1;
	localparam int             N_DIRECTED   = 18;
	localparam int             RANDOM_WORDS = 130;
	localparam int             HOLD_AFTER   = 40;
	localparam int             LONG_HOLD    = 400;
	localparam int             DRAIN_CYCLES = 3 * bse_pkg::DEPTH;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_ready;
	bse_pkg::word_t value = '0;
	logic           last = 1'b0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	bse_pkg::word_t sorted_value;
	logic           final_res;

	word_req_t      stim_q[$];
	word_req_t      shown = '0;
	bse_pkg::word_t held_words[$];
	sorted_t        expected_sorted[$];
	int             words_planned = 0;
	int             words_taken = 0;
	int             mismatches = 0;
	int             gap_left = 0;
	int             burst_left = 0;
	int             hold_left = 0;
	int             mode_left = 0;
	bit             held_once = 1'b0;
	rx_mode_t       rx_mode = RX_FREE;
	logic [15:0]    stall_pat = 16'hffff;

	// Directed sets: lone extremes, mixed extremes, equal values, reversed order
	word_req_t directed_rows [N_DIRECTED] = '{
		'{W_MIN,  1'b1, 1'b1, W_MIN},
		'{W_MAX,  1'b1, 1'b1, W_MAX},
		'{32'sd0, 1'b1, 1'b1, 32'sd0},
		'{W_ONES, 1'b1, 1'b1, W_ONES},
		'{W_MAX,  1'b0, 1'b0, 32'sd0},
		'{W_MIN,  1'b0, 1'b0, 32'sd0},
		'{32'sd0, 1'b0, 1'b0, 32'sd0},
		'{W_ONES, 1'b0, 1'b0, 32'sd0},
		'{32'sd1, 1'b1, 1'b0, 32'sd0},
		'{32'sd5, 1'b0, 1'b0, 32'sd0},
		'{32'sd5, 1'b0, 1'b0, 32'sd0},
		'{-32'sd5, 1'b0, 1'b0, 32'sd0},
		'{32'sd5, 1'b1, 1'b0, 32'sd0},
		'{32'sh7fff_fffe, 1'b0, 1'b0, 32'sd0},
		'{32'sh4000_0000, 1'b0, 1'b0, 32'sd0},
		'{32'sh8000_0001, 1'b1, 1'b0, 32'sd0},
		'{W_MIN,  1'b0, 1'b0, 32'sd0},
		'{W_MIN,  1'b1, 1'b0, 32'sd0}
	};

	bubble_sort_engine DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value        (value),
		.last         (last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sorted_value (sorted_value),
		.final_res    (final_res)
	);

	always #4 clk = ~clk;

	task automatic flag_mismatch(input string what);
		if (mismatches < 50) $display("%0t mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// Bias towards extremes and a narrow band so that equal words turn up
	function automatic bse_pkg::word_t pick_value();
		case ($urandom_range(0, 3))
			0: return bse_pkg::word_t'($urandom_range(0, 16)) - 32'sd8;
			1: begin
				case ($urandom_range(0, 3))
					0: return W_MIN;
					1: return W_MAX;
					2: return W_MIN + 32'sd1;
					default: return W_MAX - 32'sd1;
				endcase
			end
			default: return bse_pkg::word_t'($urandom);
		endcase
	endfunction

	// Collect the set; on the closing word sort it and queue the words in order
	function automatic void take_word(bse_pkg::word_t v, logic l);
		bse_pkg::word_t pile[$];
		bse_pkg::word_t t;
		sorted_t        r;
		if (held_words.size() < bse_pkg::DEPTH) held_words.push_back(v);
		if (l) begin
			pile = held_words;
			// sink the largest remaining word to the end on each pass
			for (int p = 0; p + 1 < pile.size(); p++) begin
				for (int k = 0; k + 1 < pile.size() - p; k++) begin
					if (pile[k] > pile[k + 1]) begin
						t = pile[k];
						pile[k] = pile[k + 1];
						pile[k + 1] = t;
					end
				end
			end
			foreach (pile[k]) begin
				r.v = pile[k];
				r.fin = (k == pile.size() - 1);
				expected_sorted.push_back(r);
			end
			held_words.delete();
		end
	endfunction

	// Offer words in bursts with random gaps; hold each word until taken
	always @(posedge clk) begin : sender
		word_req_t nxt;
		if (arst_n && (!in_valid || in_ready)) begin
			if (gap_left != 0 || stim_q.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left != 0) gap_left--;
			end else begin
				nxt = stim_q.pop_front();
				shown <= nxt;
				in_valid <= 1'b1;
				value <= nxt.v;
				last <= nxt.l;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					case ($urandom_range(0, 7))
						0, 1: gap_left = 0;
						2: gap_left = $urandom_range(20, 40);
						default: gap_left = $urandom_range(1, 8);
					endcase
				end
			end
		end
	end

	// Stall the output: one long hold-off, then free, pattern or coin-toss stretches
	always @(posedge clk) begin : receiver
		if (!held_once && words_taken >= HOLD_AFTER && out_valid) begin
			held_once = 1'b1;
			hold_left = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (mode_left != 0) begin
				mode_left--;
			end else begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(8, 64);
				stall_pat = 16'($urandom) | 16'h0001;
			end
			stall_pat = {stall_pat[14:0], stall_pat[15]};
			case (rx_mode)
				RX_FREE: out_ready <= 1'b1;
				RX_PATTERN: out_ready <= stall_pat[0];
				default: out_ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	// Predict on each word taken in, check each word handed out
	always @(posedge clk) begin : monitor
		sorted_t want;
		if (in_valid && in_ready) begin
			words_taken <= words_taken + 1;
			if (shown.typed) begin
				want.v = shown.exp_v;
				want.fin = 1'b1;
				expected_sorted.push_back(want);
				held_words.delete();
			end else begin
				take_word(value, last);
			end
		end
		if (out_valid && out_ready) begin
			if (expected_sorted.size() == 0) begin
				flag_mismatch($sformatf("word %0d with nothing expected", sorted_value));
			end else begin
				want = expected_sorted.pop_front();
				if (sorted_value !== want.v)
					flag_mismatch($sformatf("sorted_value %0d, expected %0d",
						sorted_value, want.v));
				if (final_res !== want.fin)
					flag_mismatch($sformatf("final_res %b, expected %b (word %0d)",
						final_res, want.fin, want.v));
			end
		end
	end

	initial begin : main
		word_req_t req;
		int        set_len;
		int        rand_left;
		foreach (directed_rows[i]) stim_q.push_back(directed_rows[i]);
		// an overfull set first, whose closing word is itself dropped, then small sets
		rand_left = RANDOM_WORDS;
		set_len = $urandom_range(bse_pkg::DEPTH + 1, bse_pkg::DEPTH + 4);
		while (rand_left > 0) begin
			for (int k = 0; k < set_len; k++) begin
				req = '0;
				req.v = pick_value();
				req.l = (k == set_len - 1);
				stim_q.push_back(req);
			end
			rand_left -= set_len;
			set_len = $urandom_range(1, 10);
		end
		words_planned = stim_q.size();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (words_taken != words_planned) @(posedge clk);
		while (expected_sorted.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Guard against a hung handshake
	initial begin : watchdog
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
